### hw/rtl/vbfe_pkg.sv
// ============================================================================
// vbfe_pkg
// Shared types and codes of the voxel boundary face extractor.
// ============================================================================
`default_nettype none

package vbfe_pkg;

    // Face direction codes, in emission order
    localparam logic [2:0] DIR_UP    = 3'd0;  // +y
    localparam logic [2:0] DIR_DOWN  = 3'd1;  // -y
    localparam logic [2:0] DIR_NORTH = 3'd2;  // -z
    localparam logic [2:0] DIR_SOUTH = 3'd3;  // +z
    localparam logic [2:0] DIR_EAST  = 3'd4;  // +x
    localparam logic [2:0] DIR_WEST  = 3'd5;  // -x
    localparam int         NUM_DIRS  = 6;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    localparam logic [7:0] SIZE_RESET = 8'd128;

    // Raw size registers plus a strobe for any valid register write
    typedef struct packed {
        logic [7:0] size_x;
        logic [7:0] size_y;
        logic [7:0] size_z;
        logic       wr;
    } t_cfg;

    // One resolved solid voxel: face mask (bit = direction code) and position
    typedef struct packed {
        logic [NUM_DIRS-1:0] mask;
        logic [6:0]          x;
        logic [6:0]          y;
        logic [6:0]          z;
    } t_face_job;

endpackage

`default_nettype wire

### hw/rtl/vbfe_occ_mem.sv
// ============================================================================
// vbfe_occ_mem
// Occupancy ring memory: one bit per entry, one write and two registered
// reads per cycle.
// ============================================================================
`default_nettype none

module vbfe_occ_mem #(
    parameter  int DEPTH = 32769,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic          i_wdata,
    input  wire logic [AW-1:0] i_raddr_a,
    input  wire logic [AW-1:0] i_raddr_b,
    output logic               o_rdata_a,
    output logic               o_rdata_b
);

    logic r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

### hw/rtl/vbfe_ctrl.sv
// ============================================================================
// vbfe_ctrl
// Write/resolve sequencer: tracks positions, writes occupancy bits and reads
// the center and five neighbors of the voxel being resolved, two at a time.
// ============================================================================
`default_nettype none

module vbfe_ctrl #(
    parameter  int MAX_X = 128,
    parameter  int MAX_Y = 128,
    parameter  int MAX_Z = 128,
    localparam int DEPTH = 2 * MAX_X * MAX_Y + 1,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire vbfe_pkg::t_cfg     i_cfg,
    // input item channel
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_kind,
    input  wire logic [7:0]         i_voxel,
    // occupancy memory
    output logic                    o_mem_we,
    output logic [AW-1:0]           o_mem_waddr,
    output logic                    o_mem_wdata,
    output logic [AW-1:0]           o_mem_raddr_a,
    output logic [AW-1:0]           o_mem_raddr_b,
    input  wire logic               i_mem_rdata_a,
    input  wire logic               i_mem_rdata_b,
    // face job to emitter
    output logic                    o_job_valid,
    output vbfe_pkg::t_face_job     o_job,
    input  wire logic               i_job_ready
);

    import vbfe_pkg::*;

    localparam int XSW = $clog2(MAX_X + 1);
    localparam int YSW = $clog2(MAX_Y + 1);
    localparam int ZSW = $clog2(MAX_Z + 1);
    localparam int XCW = $clog2(MAX_X);
    localparam int YCW = $clog2(MAX_Y);
    localparam int ZCW = $clog2(MAX_Z);
    localparam int PW  = $clog2(MAX_X * MAX_Y + 1);

    localparam logic [AW:0]   DEPTH_V = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] PTR_TOP = AW'(DEPTH - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_R0   = 3'd1;  // issue center, east
    localparam logic [2:0] S_R1   = 3'd2;  // issue west, up
    localparam logic [2:0] S_R2   = 3'd3;  // issue down, north
    localparam logic [2:0] S_R3   = 3'd4;  // evaluate, hand off

    function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] a);
        return (a == PTR_TOP) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] dec_wrap(input logic [AW-1:0] a);
        return (a == '0) ? PTR_TOP : a - 1'b1;
    endfunction

    function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_V) begin
            s = s - DEPTH_V;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] sub_wrap(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} - {1'b0, b};
        if (a < b) begin
            s = s + DEPTH_V;
        end
        return s[AW-1:0];
    endfunction

    // clamped sizes and last coordinates
    logic [XSW-1:0]     sx;
    logic [YSW-1:0]     sy;
    logic [ZSW-1:0]     sz;
    logic [XCW-1:0]     lx;
    logic [YCW-1:0]     ly;
    logic [ZCW-1:0]     lz;
    logic [XSW+YSW-1:0] plane_prod;

    always_comb begin
        sx = (i_cfg.size_x == '0) ? XSW'(1) :
             (32'(i_cfg.size_x) > 32'(MAX_X)) ? XSW'(MAX_X) : XSW'(i_cfg.size_x);
        sy = (i_cfg.size_y == '0) ? YSW'(1) :
             (32'(i_cfg.size_y) > 32'(MAX_Y)) ? YSW'(MAX_Y) : YSW'(i_cfg.size_y);
        sz = (i_cfg.size_z == '0) ? ZSW'(1) :
             (32'(i_cfg.size_z) > 32'(MAX_Z)) ? ZSW'(MAX_Z) : ZSW'(i_cfg.size_z);
        lx = XCW'(sx - XSW'(1));
        ly = YCW'(sy - YSW'(1));
        lz = ZCW'(sz - ZSW'(1));
        plane_prod = sx * sy;
    end

    logic [2:0]    r_state, n_state;
    logic          r_settle;
    logic [PW-1:0] r_plane;
    logic [PW-1:0] r_gap;     // voxels written but not yet resolved
    logic          r_full;    // whole volume received
    logic [AW-1:0] r_wr_ptr;
    logic [XCW-1:0] r_wx;
    logic [YCW-1:0] r_wy;
    logic [ZCW-1:0] r_wz;
    logic [AW-1:0] r_rd_ptr;
    logic [XCW-1:0] r_rx;
    logic [YCW-1:0] r_ry;
    logic [ZCW-1:0] r_rz;

    // voxel under resolution
    logic [AW-1:0]  r_cur_ptr;
    logic [XCW-1:0] r_cur_x;
    logic [YCW-1:0] r_cur_y;
    logic [ZCW-1:0] r_cur_z;
    logic           r_south;  // occupancy one plane ahead (the newest voxel)
    logic           r_occ_c, r_occ_e, r_occ_w, r_occ_u;

    logic               accept, vox_wr, start_vox, start_flush, start;
    logic               wr_last, rd_last, job_ok;
    logic [NUM_DIRS-1:0] mask;

    assign wr_last = (r_wx == lx) && (r_wy == ly) && (r_wz == lz);
    assign rd_last = (r_rx == lx) && (r_ry == ly) && (r_rz == lz);

    always_comb begin
        mask = '0;
        if (r_occ_c) begin
            mask[DIR_UP]    = (r_cur_y == ly)  || !r_occ_u;
            mask[DIR_DOWN]  = (r_cur_y == '0)  || !i_mem_rdata_a;
            mask[DIR_NORTH] = (r_cur_z == '0)  || !i_mem_rdata_b;
            mask[DIR_SOUTH] = (r_cur_z == lz)  || !r_south;
            mask[DIR_EAST]  = (r_cur_x == lx)  || !r_occ_e;
            mask[DIR_WEST]  = (r_cur_x == '0)  || !r_occ_w;
        end
    end

    assign job_ok      = (mask == '0) || i_job_ready;
    assign o_ready     = !r_settle && ((r_state == S_IDLE) || ((r_state == S_R3) && job_ok));
    assign accept      = i_valid && o_ready;
    assign vox_wr      = accept && !i_kind && !r_full;
    assign start_vox   = vox_wr && (r_gap == r_plane);
    assign start_flush = accept && i_kind && r_full;
    assign start       = start_vox || start_flush;

    assign o_mem_we    = vox_wr;
    assign o_mem_waddr = r_wr_ptr;
    assign o_mem_wdata = |i_voxel;

    assign o_job_valid = (r_state == S_R3);
    assign o_job.mask  = mask;
    assign o_job.x     = 7'(r_cur_x);
    assign o_job.y     = 7'(r_cur_y);
    assign o_job.z     = 7'(r_cur_z);

    always_comb begin
        case (r_state)
            S_R1: begin
                o_mem_raddr_a = dec_wrap(r_cur_ptr);
                o_mem_raddr_b = add_wrap(r_cur_ptr, AW'(sx));
            end
            S_R2, S_R3: begin
                o_mem_raddr_a = sub_wrap(r_cur_ptr, AW'(sx));
                o_mem_raddr_b = sub_wrap(r_cur_ptr, AW'(r_plane));
            end
            default: begin
                o_mem_raddr_a = r_cur_ptr;
                o_mem_raddr_b = inc_wrap(r_cur_ptr);
            end
        endcase
    end

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = start ? S_R0 : S_IDLE;
            S_R0:    n_state = S_R1;
            S_R1:    n_state = S_R2;
            S_R2:    n_state = S_R3;
            S_R3:    n_state = job_ok ? (start ? S_R0 : S_IDLE) : S_R3;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_settle <= 1'b0;
            r_gap    <= '0;
            r_full   <= 1'b0;
            r_wr_ptr <= '0;
            r_wx     <= '0;
            r_wy     <= '0;
            r_wz     <= '0;
            r_rd_ptr <= '0;
            r_rx     <= '0;
            r_ry     <= '0;
            r_rz     <= '0;
        end else begin
            r_state  <= n_state;
            r_settle <= i_cfg.wr;
            if (i_cfg.wr) begin
                r_gap    <= '0;
                r_full   <= 1'b0;
                r_wr_ptr <= '0;
                r_wx     <= '0;
                r_wy     <= '0;
                r_wz     <= '0;
                r_rd_ptr <= '0;
                r_rx     <= '0;
                r_ry     <= '0;
                r_rz     <= '0;
            end else begin
                if (vox_wr) begin
                    r_wr_ptr <= inc_wrap(r_wr_ptr);
                    if (r_wx == lx) begin
                        r_wx <= '0;
                        if (r_wy == ly) begin
                            r_wy <= '0;
                            r_wz <= (r_wz == lz) ? '0 : r_wz + 1'b1;
                        end else begin
                            r_wy <= r_wy + 1'b1;
                        end
                    end else begin
                        r_wx <= r_wx + 1'b1;
                    end
                    if (wr_last) begin
                        r_full <= 1'b1;
                    end
                    if (!start_vox) begin
                        r_gap <= r_gap + 1'b1;
                    end
                end
                if (start) begin
                    r_rd_ptr <= inc_wrap(r_rd_ptr);
                    if (r_rx == lx) begin
                        r_rx <= '0;
                        if (r_ry == ly) begin
                            r_ry <= '0;
                            r_rz <= (r_rz == lz) ? '0 : r_rz + 1'b1;
                        end else begin
                            r_ry <= r_ry + 1'b1;
                        end
                    end else begin
                        r_rx <= r_rx + 1'b1;
                    end
                end
                if (start_flush) begin
                    if (rd_last) begin
                        // end of volume: ready for the next one
                        r_gap    <= '0;
                        r_full   <= 1'b0;
                        r_wr_ptr <= '0;
                        r_rd_ptr <= '0;
                    end else begin
                        r_gap <= r_gap - 1'b1;
                    end
                end
            end
        end
    end

    // derived size and working registers
    always_ff @(posedge i_clk) begin
        r_plane <= PW'(plane_prod);
        if (start) begin
            r_cur_ptr <= r_rd_ptr;
            r_cur_x   <= r_rx;
            r_cur_y   <= r_ry;
            r_cur_z   <= r_rz;
            r_south   <= start_vox && (|i_voxel);
        end
        if (r_state == S_R1) begin
            r_occ_c <= i_mem_rdata_a;
            r_occ_e <= i_mem_rdata_b;
        end
        if (r_state == S_R2) begin
            r_occ_w <= i_mem_rdata_a;
            r_occ_u <= i_mem_rdata_b;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/vbfe_face_out.sv
// ============================================================================
// vbfe_face_out
// Face emitter: walks a face mask in direction order, one face per cycle
// while the output is not stalled, into a registered output stage.
// ============================================================================
`default_nettype none

module vbfe_face_out (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_job_valid,
    input  wire vbfe_pkg::t_face_job i_job,
    output logic                     o_job_ready,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [2:0]               o_face_dir,
    output logic [6:0]               o_coord_x,
    output logic [6:0]               o_coord_y,
    output logic [6:0]               o_coord_z,
    output logic                     o_last_face
);

    import vbfe_pkg::*;

    logic [NUM_DIRS-1:0] r_pend, rest;
    logic [6:0]          r_jx, r_jy, r_jz;
    logic [2:0]          sel;
    logic                load_out, job_take;

    always_comb begin
        sel = DIR_UP;
        for (int d = NUM_DIRS - 1; d >= 0; d--) begin
            if (r_pend[d]) begin
                sel = 3'(d);
            end
        end
        rest      = r_pend;
        rest[sel] = 1'b0;
    end

    assign o_job_ready = (r_pend == '0);
    assign job_take    = i_job_valid && o_job_ready;
    assign load_out    = !o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            o_valid <= 1'b0;
        end else begin
            if (job_take) begin
                r_pend <= i_job.mask;
            end else if (load_out) begin
                r_pend <= rest;
            end
            if (load_out) begin
                o_valid <= |r_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_take) begin
            r_jx <= i_job.x;
            r_jy <= i_job.y;
            r_jz <= i_job.z;
        end
        if (load_out && (|r_pend)) begin
            o_face_dir  <= sel;
            o_coord_x   <= r_jx;
            o_coord_y   <= r_jy;
            o_coord_z   <= r_jz;
            o_last_face <= (rest == '0);
        end
    end

endmodule

`default_nettype wire

### hw/rtl/voxel_boundary_face_extractor.sv
// ============================================================================
// voxel_boundary_face_extractor
// Streams voxel bytes in raster order and emits the boundary faces of every
// solid voxel once its six neighbors are known.
// ============================================================================
//
//  channel   | direction | handshake        | transaction payload
//  ----------+-----------+------------------+--------------------------------
//  input     | in        | i_valid/o_ready  | i_kind, i_voxel
//  faces     | out       | o_valid/i_ready  | o_face_dir, o_coord_x/y/z,
//            |           |                  | o_last_face
//  config    | in        | psel/penable     | paddr, pwdata, prdata (APB)
//
//  Sequencing: an item that resolves no voxel does not enter the resolve
//  states. One that resolves a voxel passes S_R0, S_R1 and S_R2, the three
//  two-port reads of the occupancy memory, then S_R3 (evaluate/hand-off);
//  faces then leave at one per cycle while the output is not stalled.
//  Reset: synchronous, active low; positions and handshake state clear at
//  once, the occupancy memory is not cleared (no entry is used unwritten).
//  Stalls: the emitter holds up to one voxel's faces while the sequencer
//  works on the next; a register write holds o_ready low in the next cycle.
//
`default_nettype none

module voxel_boundary_face_extractor #(
    parameter int MAX_X = 128,
    parameter int MAX_Y = 128,
    parameter int MAX_Z = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input items
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_voxel,
    // faces
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_face_dir,
    output logic [6:0]       o_coord_x,
    output logic [6:0]       o_coord_y,
    output logic [6:0]       o_coord_z,
    output logic             o_last_face,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import vbfe_pkg::*;

    // ring of two planes plus one voxel
    localparam int OCC_DEPTH = 2 * MAX_X * MAX_Y + 1;
    localparam int OCC_AW    = $clog2(OCC_DEPTH);

    // ---------------------------------------------------------------------
    // Register file
    // ---------------------------------------------------------------------
    logic [7:0] r_size_x, r_size_y, r_size_z;
    logic [1:0] reg_idx;
    logic       cfg_wr, reg_hit;
    t_cfg       cfg;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;
    // a write to a listed register also restarts the volume
    assign reg_hit = (reg_idx == REG_SIZE_X) || (reg_idx == REG_SIZE_Y) ||
                     (reg_idx == REG_SIZE_Z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RESET;
            r_size_y <= SIZE_RESET;
            r_size_z <= SIZE_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SIZE_X: r_size_x <= pwdata[7:0];
                REG_SIZE_Y: r_size_y <= pwdata[7:0];
                REG_SIZE_Z: r_size_z <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SIZE_X: prdata = {24'd0, r_size_x};
            REG_SIZE_Y: prdata = {24'd0, r_size_y};
            REG_SIZE_Z: prdata = {24'd0, r_size_z};
            default:    prdata = '0;
        endcase
    end

    assign cfg.size_x = r_size_x;
    assign cfg.size_y = r_size_y;
    assign cfg.size_z = r_size_z;
    assign cfg.wr     = cfg_wr && reg_hit;

    // ---------------------------------------------------------------------
    // Sequencer, occupancy memory, face emitter
    // ---------------------------------------------------------------------
    logic              mem_we, mem_wdata, mem_rdata_a, mem_rdata_b;
    logic [OCC_AW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
    logic              job_valid, job_ready;
    t_face_job         job;

    vbfe_ctrl #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_voxel       (i_voxel),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_raddr_a (mem_raddr_a),
        .o_mem_raddr_b (mem_raddr_b),
        .i_mem_rdata_a (mem_rdata_a),
        .i_mem_rdata_b (mem_rdata_b),
        .o_job_valid   (job_valid),
        .o_job         (job),
        .i_job_ready   (job_ready)
    );

    vbfe_occ_mem #(
        .DEPTH (OCC_DEPTH)
    ) u_occ_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (mem_rdata_a),
        .o_rdata_b (mem_rdata_b)
    );

    vbfe_face_out u_face_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_ready (job_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_face_dir  (o_face_dir),
        .o_coord_x   (o_coord_x),
        .o_coord_y   (o_coord_y),
        .o_coord_z   (o_coord_z),
        .o_last_face (o_last_face)
    );

endmodule

`default_nettype wire
